// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held
`define SLXP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also runs during reset
`define SLXP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/slxp_pkg.sv -----
package slxp_pkg;

  // Frame parser phases
  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_CODE    = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_LEN_HI  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CHECK   = 3'd6
  } slxp_phase_t;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD    = 2'd0;
  localparam logic [1:0] KIND_CHECK_GOOD = 2'd1;
  localparam logic [1:0] KIND_CHECK_FAIL = 2'd2;

  // Configuration register indexes
  localparam logic CFG_SYNC_FIRST  = 1'b0;
  localparam logic CFG_SYNC_SECOND = 1'b1;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'd80;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd83;

  // One result beat
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  frame_code;
    logic [7:0]  payload_data;
    logic [15:0] position;
    logic [7:0]  computed_check;
  } slxp_result_t;

endpackage

// ----- rtl/slxp_core.sv -----
module slxp_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  logic                 push_in,
  input  logic [7:0]           rx_byte,
  output logic                 res_valid,
  output slxp_pkg::slxp_result_t res
);
  import slxp_pkg::*;

  slxp_phase_t phase_r, phase_nxt;
  logic [7:0]  sync_first_r, sync_second_r;
  logic [7:0]  code_r, code_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [15:0] cnt_inc;

  // Sync byte registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SYNC_FIRST) sync_first_r <= cfg_wdata;
      else                             sync_second_r <= cfg_wdata;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      code_r  <= 8'd0;
      len_r   <= 16'd0;
      cnt_r   <= 16'd0;
      xor_r   <= 8'd0;
    end else if (push_in) begin
      phase_r <= phase_nxt;
      code_r  <= code_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      xor_r   <= xor_nxt;
    end
  end

  assign cnt_inc = cnt_r + 16'd1;

  // Next state and result for this beat
  always_comb begin
    phase_nxt = phase_r;
    code_nxt  = code_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    xor_nxt   = xor_r;
    res_valid = 1'b0;
    res.kind           = KIND_PAYLOAD;
    res.frame_code     = code_r;
    res.payload_data   = rx_byte;
    res.position       = cnt_r;
    res.computed_check = xor_r ^ rx_byte;
    unique case (phase_r)
      PH_HUNT1: begin
        if (rx_byte == sync_first_r) phase_nxt = PH_HUNT2;
      end
      PH_HUNT2: begin
        phase_nxt = (rx_byte == sync_second_r) ? PH_CODE : PH_HUNT1;
      end
      PH_CODE: begin
        code_nxt  = rx_byte;
        xor_nxt   = rx_byte;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_nxt   = {8'd0, rx_byte};
        xor_nxt   = xor_r ^ rx_byte;
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_nxt   = {rx_byte, len_r[7:0]};
        xor_nxt   = xor_r ^ rx_byte;
        cnt_nxt   = 16'd0;
        // empty frame skips straight to the checksum byte
        phase_nxt = ({rx_byte, len_r[7:0]} == 16'd0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        res_valid = 1'b1;
        xor_nxt   = xor_r ^ rx_byte;
        cnt_nxt   = cnt_inc;
        if (cnt_inc >= len_r) phase_nxt = PH_CHECK;
      end
      PH_CHECK: begin
        res_valid          = 1'b1;
        res.kind           = (xor_r == rx_byte) ? KIND_CHECK_GOOD : KIND_CHECK_FAIL;
        res.computed_check = xor_r;
        cnt_nxt            = 16'd0;
        phase_nxt          = PH_HUNT1;
      end
      default: begin
        phase_nxt = PH_HUNT1;
      end
    endcase
  end

endmodule

// ----- rtl/slxp_skid.sv -----
module slxp_skid (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  slxp_pkg::slxp_result_t  push_data,
  output logic                    full,
  output logic                    out_v,
  input  logic                    out_hold,
  output slxp_pkg::slxp_result_t  out_data
);
  import slxp_pkg::*;

  logic         main_v_r, skid_v_r;
  slxp_result_t main_r, skid_r;
  logic         pop;

  assign pop      = main_v_r & ~out_hold;
  assign full     = skid_v_r;
  assign out_v    = main_v_r;
  assign out_data = main_r;

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || pop) begin
      if (skid_v_r) skid_v_r <= 1'b0;
      else          main_v_r <= push;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (!main_v_r || pop) begin
      main_r <= skid_v_r ? skid_r : push_data;
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule

// ----- rtl/sync_length_xor_packet_parser.sv -----
// A result beat is registered in the output buffer before it is offered on out_.
// Throughput: one byte per cycle while in_stall is low; the parser state updates in a single pass per byte.
// A two-entry output buffer keeps input flowing while one result waits; in_stall
// rises only when both entries hold results.
// Reset (rst_n low, synchronous): hunt for first sync, sync bytes 80 and 83,
// output buffer empty.
`include "assert_macros.svh"

module sync_length_xor_packet_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_frame_code,
  output logic [7:0]  out_payload_data,
  output logic [15:0] out_position,
  output logic [7:0]  out_computed_check
);
  import slxp_pkg::*;

  logic         accept;
  logic         res_valid;
  slxp_result_t res, out_res;

  assign accept = in_valid & ~in_stall;

  // Parser
  slxp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push_in   (accept),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output buffer
  slxp_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept & res_valid),
    .push_data (res),
    .full      (in_stall),
    .out_v     (out_valid),
    .out_hold  (out_stall),
    .out_data  (out_res)
  );

  assign out_kind           = out_res.kind;
  assign out_frame_code     = out_res.frame_code;
  assign out_payload_data   = out_res.payload_data;
  assign out_position       = out_res.position;
  assign out_computed_check = out_res.computed_check;

  // Checks
  `SLXP_ASSERT(a_stall_needs_result, in_stall |-> out_valid, "stall without a pending result")
  `SLXP_ASSERT(a_stall_rise_cause, $rose(in_stall) |-> $past(out_valid && out_stall), "bad stall")
  `SLXP_ASSERT(a_kind_legal, out_valid |-> (out_kind <= KIND_CHECK_FAIL), "illegal result kind")
  `SLXP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_valid && !in_stall), "buffer not empty")

endmodule
